// ----- sv/dlsm_pkg.sv -----
package dlsm_pkg;

  localparam int WINDOW_DEF = 4096;

  localparam logic [1:0] CMD_ARRIVAL = 2'd0;
  localparam logic [1:0] CMD_PULL    = 2'd1;
  localparam logic [1:0] CMD_END     = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  localparam logic [2:0] KIND_STORED    = 3'd0;
  localparam logic [2:0] KIND_DELIVERED = 3'd1;
  localparam logic [2:0] KIND_HOLE      = 3'd2;
  localparam logic [2:0] KIND_WAIT      = 3'd3;
  localparam logic [2:0] KIND_EOC       = 3'd4;
  localparam logic [2:0] KIND_IGNORED   = 3'd5;

  typedef struct packed {
    logic        valid;
    logic        marker;
    logic [31:0] tag;
  } slot_entry_t;

  localparam int EntryW = $bits(slot_entry_t);

  // absolute sequence nearest ref_seq whose low 16 bits equal raw
  function automatic logic [31:0] unwrap_near(logic [15:0] raw, logic [31:0] ref_seq);
    logic [15:0] d;
    d = raw - ref_seq[15:0];
    return ref_seq + {{16{d[15]}}, d};
  endfunction

  // a is strictly ahead of b in wrapping order
  function automatic logic ahead(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

// ----- sv/dlsm_ram.sv -----
module dlsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/dual_leg_sequence_merge_window_top.sv -----
// Seamless merge of two redundant datagram legs by sequence number. Each input word is a
// command: an arrival (stored in the leg's window slot unless dual mode is off for leg 1 or
// the leg has ended; the returned slot is where the payload goes), a pull (delivers the
// cursor from leg 0, else leg 1 in dual mode, or skips a hole, waits or reports end of
// capture; the registered read of the two leg memories is followed by the decision), a
// leg-ended mark or a restart. After reset and after every restart the slot memories are
// swept clear, one slot of both legs per cycle, with in_stall held high; configuration
// writes are taken throughout. One item is in flight at a time; in_stall stays high while
// a result waits in the output register and drops in the cycle that the result is taken.
module dual_leg_sequence_merge_window_top #(
  parameter int WINDOW = dlsm_pkg::WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic                      in_leg,
  input  logic [15:0]               in_raw_seq,
  input  logic                      in_mark_in,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_kind,
  output logic                      out_leg,
  output logic [$clog2(WINDOW)-1:0] out_slot,
  output logic                      out_mark_out,
  output logic [31:0]               out_abs_seq,
  output logic [31:0]               out_hole_count,
  output logic [31:0]               out_second_fill_count,

  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int SlotW = $clog2(WINDOW);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [SlotW-1:0]  clr_addr_r, clr_addr_nxt;
  logic              dual_r;
  logic [31:0]       cursor_r, cursor_nxt;
  logic              anchored_r, anchored_nxt;
  logic [31:0]       first_seq_r, first_seq_nxt;
  logic              have_first_r, have_first_nxt;
  logic [1:0][31:0]  last_r, last_nxt;
  logic [1:0]        have_last_r, have_last_nxt;
  logic [1:0]        ended_r, ended_nxt;
  logic [31:0]       holes_r, holes_nxt;
  logic [31:0]       fills_r, fills_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_kind_r, out_kind_nxt;
  logic              out_leg_r, out_leg_nxt;
  logic [SlotW-1:0]  out_slot_r, out_slot_nxt;
  logic              out_mark_r, out_mark_nxt;
  logic [31:0]       out_seq_r, out_seq_nxt;
  logic [31:0]       out_holes_r, out_holes_nxt;
  logic [31:0]       out_fills_r, out_fills_nxt;

  logic [1:0]                         ram_we;
  logic [SlotW-1:0]                   ram_waddr;
  dlsm_pkg::slot_entry_t              ram_wdata;
  logic                               ram_re;
  logic [SlotW-1:0]                   ram_raddr;
  logic [1:0][dlsm_pkg::EntryW-1:0]   ram_rdata;
  dlsm_pkg::slot_entry_t              rd0, rd1;

  logic        out_free;
  logic        in_accept;
  logic        cfg_wr;
  logic [31:0] arr_seq;
  logic [31:0] cur_eff;
  logic        hit0, hit1;
  logic        ahead0, ahead1;
  logic        drained0, drained1, passed0, passed1;

  genvar gi;
  generate
    for (gi = 0; gi < 2; gi++) begin : g_leg_ram
      dlsm_ram #(
        .WIDTH (dlsm_pkg::EntryW),
        .DEPTH (WINDOW)
      ) u_ram (
        .clk   (clk),
        .we    (ram_we[gi]),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata[gi])
      );
    end
  endgenerate

  assign rd0 = dlsm_pkg::slot_entry_t'(ram_rdata[0]);
  assign rd1 = dlsm_pkg::slot_entry_t'(ram_rdata[1]);

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, dual_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dual_r <= 1'b0;
    end else if (cfg_wr && !paddr[2]) begin
      dual_r <= pwdata[0];
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (have_last_r[in_leg]) begin
      arr_seq = dlsm_pkg::unwrap_near(in_raw_seq, last_r[in_leg]);
    end else if (anchored_r) begin
      arr_seq = dlsm_pkg::unwrap_near(in_raw_seq, cursor_r);
    end else begin
      arr_seq = {16'd0, in_raw_seq};
    end
  end

  assign cur_eff  = (!anchored_r && have_first_r) ? first_seq_r : cursor_r;

  assign hit0     = rd0.valid && (rd0.tag == cursor_r);
  assign hit1     = rd1.valid && (rd1.tag == cursor_r);
  assign ahead0   = have_last_r[0] && dlsm_pkg::ahead(last_r[0], cursor_r);
  assign ahead1   = have_last_r[1] && dlsm_pkg::ahead(last_r[1], cursor_r);
  assign drained0 = ended_r[0] && !ahead0;
  assign drained1 = ended_r[1] && !ahead1;
  assign passed0  = ended_r[0] || ahead0;
  assign passed1  = ended_r[1] || ahead1;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cursor_nxt     = cursor_r;
    anchored_nxt   = anchored_r;
    first_seq_nxt  = first_seq_r;
    have_first_nxt = have_first_r;
    last_nxt       = last_r;
    have_last_nxt  = have_last_r;
    ended_nxt      = ended_r;
    holes_nxt      = holes_r;
    fills_nxt      = fills_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_leg_nxt    = out_leg_r;
    out_slot_nxt   = out_slot_r;
    out_mark_nxt   = out_mark_r;
    out_seq_nxt    = out_seq_r;
    out_holes_nxt  = out_holes_r;
    out_fills_nxt  = out_fills_r;

    ram_we    = 2'b00;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cur_eff[SlotW-1:0];

    case (state_r)
      ST_CLEAR: begin
        ram_we       = 2'b11;
        clr_addr_nxt = clr_addr_r + SlotW'(1);
        if (&clr_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          out_kind_nxt  = dlsm_pkg::KIND_IGNORED;
          out_leg_nxt   = 1'b0;
          out_slot_nxt  = '0;
          out_mark_nxt  = 1'b0;
          out_seq_nxt   = 32'd0;
          out_holes_nxt = holes_r;
          out_fills_nxt = fills_r;
          case (in_cmd)
            dlsm_pkg::CMD_ARRIVAL: begin
              out_valid_nxt = 1'b1;
              out_leg_nxt   = in_leg;
              if (!(in_leg && !dual_r) && !ended_r[in_leg]) begin
                if (!in_leg && !have_first_r) begin
                  have_first_nxt = 1'b1;
                  first_seq_nxt  = arr_seq;
                end
                ram_we[in_leg]        = 1'b1;
                ram_waddr             = arr_seq[SlotW-1:0];
                ram_wdata.valid       = 1'b1;
                ram_wdata.marker      = in_mark_in;
                ram_wdata.tag         = arr_seq;
                last_nxt[in_leg]      = arr_seq;
                have_last_nxt[in_leg] = 1'b1;
                out_kind_nxt          = dlsm_pkg::KIND_STORED;
                out_slot_nxt          = arr_seq[SlotW-1:0];
                out_seq_nxt           = arr_seq;
              end
            end
            dlsm_pkg::CMD_PULL: begin
              if (!anchored_r && have_first_r) begin
                cursor_nxt   = first_seq_r;
                anchored_nxt = 1'b1;
              end
              ram_re    = 1'b1;
              state_nxt = ST_LOOKUP;
            end
            dlsm_pkg::CMD_END: begin
              out_valid_nxt      = 1'b1;
              out_leg_nxt        = in_leg;
              ended_nxt[in_leg]  = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
              last_nxt      = '0;
              have_last_nxt = 2'b00;
              ended_nxt     = 2'b00;
              cursor_nxt    = 32'd0;
              anchored_nxt  = 1'b0;
              clr_addr_nxt  = '0;
              state_nxt     = ST_CLEAR;
            end
          endcase
        end
      end

      ST_LOOKUP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_leg_nxt   = 1'b0;
          out_slot_nxt  = '0;
          out_mark_nxt  = 1'b0;
          out_seq_nxt   = cursor_r;
          out_kind_nxt  = dlsm_pkg::KIND_WAIT;
          state_nxt     = ST_IDLE;
          if (!anchored_r) begin
            if (ended_r[0]) begin
              out_kind_nxt = dlsm_pkg::KIND_EOC;
            end
          end else if (hit0 || (dual_r && hit1)) begin
            out_kind_nxt = dlsm_pkg::KIND_DELIVERED;
            out_slot_nxt = cursor_r[SlotW-1:0];
            cursor_nxt   = cursor_r + 32'd1;
            if (hit0) begin
              out_mark_nxt = rd0.marker;
            end else begin
              out_leg_nxt  = 1'b1;
              out_mark_nxt = rd1.marker;
              fills_nxt    = fills_r + 32'd1;
            end
          end else if (drained0 && (!dual_r || drained1)) begin
            out_kind_nxt = dlsm_pkg::KIND_EOC;
          end else if (passed0 && (!dual_r || passed1)) begin
            out_kind_nxt = dlsm_pkg::KIND_HOLE;
            holes_nxt    = holes_r + 32'd1;
            cursor_nxt   = cursor_r + 32'd1;
          end
          out_holes_nxt = holes_nxt;
          out_fills_nxt = fills_nxt;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      cursor_r     <= 32'd0;
      anchored_r   <= 1'b0;
      first_seq_r  <= 32'd0;
      have_first_r <= 1'b0;
      last_r       <= '0;
      have_last_r  <= 2'b00;
      ended_r      <= 2'b00;
      holes_r      <= 32'd0;
      fills_r      <= 32'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      cursor_r     <= cursor_nxt;
      anchored_r   <= anchored_nxt;
      first_seq_r  <= first_seq_nxt;
      have_first_r <= have_first_nxt;
      last_r       <= last_nxt;
      have_last_r  <= have_last_nxt;
      ended_r      <= ended_nxt;
      holes_r      <= holes_nxt;
      fills_r      <= fills_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_leg_r   <= out_leg_nxt;
    out_slot_r  <= out_slot_nxt;
    out_mark_r  <= out_mark_nxt;
    out_seq_r   <= out_seq_nxt;
    out_holes_r <= out_holes_nxt;
    out_fills_r <= out_fills_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_kind              = out_kind_r;
  assign out_leg               = out_leg_r;
  assign out_slot              = out_slot_r;
  assign out_mark_out          = out_mark_r;
  assign out_abs_seq           = out_seq_r;
  assign out_hole_count        = out_holes_r;
  assign out_second_fill_count = out_fills_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("word accepted during slot clear");

  a_pull_goes_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_cmd == dlsm_pkg::CMD_PULL)) |=> (state_r == ST_LOOKUP))
    else $error("pull did not start lookup");

  a_deliver_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == dlsm_pkg::KIND_DELIVERED)) |->
      (out_abs_seq[SlotW-1:0] == out_slot))
    else $error("delivered slot does not match sequence");

  a_holes_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((holes_r == $past(holes_r)) || (holes_r == $past(holes_r) + 32'd1)))
    else $error("hole count jumped");

endmodule
